// ----- src/oaht_pkg.sv -----
// Shared types and constants for the open-addressing hash table.
// Used by the controller, the datapath, the modulo unit and the top level.
// Depends on nothing.
package oaht_pkg;

    // Field widths of the stream items.
    localparam int MODE_W   = 2;
    localparam int KEY_W    = 31;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 6;

    // Stream data widths, rounded up to whole bytes.
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 8;

    typedef logic [MODE_W-1:0]   mode_t;
    typedef logic [STATUS_W-1:0] status_t;

    // Operation codes.
    localparam mode_t MODE_INSERT = 2'd0;
    localparam mode_t MODE_SEARCH = 2'd1;
    localparam mode_t MODE_DELETE = 2'd2;

    // Result codes.
    localparam status_t ST_DONE    = 2'd0;
    localparam status_t ST_FULL    = 2'd1;
    localparam status_t ST_MISSING = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;         // capture the input transfer, start both modulo units
        logic    walk_init;    // restart the probe or scan walk
        logic    home_read;    // read the home slot
        logic    walk_run;     // issue the next probe or scan read
        logic    clr_step;     // clear one table entry after reset
        logic    wr_key;       // store the key at the checked slot
        logic    wr_free;      // free the checked slot
        logic    res_load;     // latch the result of the operation
        status_t res_status;
        logic    res_use_slot; // report the checked slot, else zero
        logic    out_load;     // move the result into the output register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        mode_t mode;
        logic  mod_busy;
        logic  hit;
        logic  walk_end;
        logic  clr_done;
        logic  out_free;
    } sts_t;

endpackage

// ----- src/oaht_mod.sv -----
// Remainder of a key by a constant modulus, by reciprocal multiplication.
// Uses oaht_pkg for the key width.
module oaht_mod #(
    parameter int MODULUS = 100
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [oaht_pkg::KEY_W-1:0]  key,
    output logic                        busy,
    output logic [$clog2(MODULUS)-1:0]  rem
);
    import oaht_pkg::*;

    localparam int RW    = $clog2(MODULUS);
    localparam int MW    = KEY_W + 1;
    localparam int PW    = KEY_W + MW;
    localparam int SHIFT = KEY_W + RW;
    localparam int QW    = PW - SHIFT;
    // Reciprocal rounded up; with this shift the quotient is exact for every key.
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(MODULUS) - 64'd1) / 64'(MODULUS);
    localparam logic [MW-1:0]    RECIP  = MW'(RECIP_FULL);
    localparam logic [KEY_W-1:0] MOD_K  = KEY_W'(MODULUS);
    localparam logic [1:0]       STAGES = 2'd2;

    logic [1:0]       cnt_reg, cnt_next;
    logic [KEY_W-1:0] key_reg;
    logic [PW-1:0]    prod_reg;
    logic [KEY_W-1:0] qd_reg;
    logic [RW-1:0]    rem_reg;
    logic [QW-1:0]    quot;
    logic [KEY_W-1:0] diff;

    // Quotient from the scaled product, then the remainder from the key.
    always_comb
    begin
        quot = prod_reg[PW-1:SHIFT];
        diff = key_reg - qd_reg;
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (start)
        begin
            cnt_next = STAGES;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    // Stage counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // Product, quotient times modulus, and remainder, one stage per cycle.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            key_reg  <= key;
            prod_reg <= {{(PW-KEY_W){1'b0}}, key} * {{(PW-MW){1'b0}}, RECIP};
        end
        qd_reg  <= KEY_W'(quot) * MOD_K;
        rem_reg <= diff[RW-1:0];
    end

    assign busy = (cnt_reg != '0);
    assign rem  = rem_reg;

endmodule

// ----- src/oaht_dp.sv -----
// Datapath of the hash table: key memory, probe generator, compare and result registers.
// Uses oaht_pkg and two oaht_mod units for the home and probe start positions.
module oaht_dp #(
    parameter int TABLE_SIZE   = 64,
    parameter int HOME_MODULUS = 100
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  oaht_pkg::cmd_t                 cmd,
    output oaht_pkg::sts_t                 sts,
    input  oaht_pkg::mode_t                in_mode,
    input  logic [oaht_pkg::KEY_W-1:0]     in_key,
    input  logic                           in_quadratic,
    input  logic                           out_ready,
    output logic                           out_valid,
    output oaht_pkg::status_t              out_status,
    output logic [oaht_pkg::SLOT_W-1:0]    out_slot
);
    import oaht_pkg::*;

    localparam int AW  = $clog2(TABLE_SIZE);
    localparam int CW  = $clog2(TABLE_SIZE + 1);
    localparam int HW  = $clog2(HOME_MODULUS);
    localparam int HCW = (HW > CW) ? HW : CW;
    localparam logic [AW:0]   TS_EXT = (AW + 1)'(TABLE_SIZE);
    localparam logic [CW-1:0] TS_CNT = CW'(TABLE_SIZE);
    localparam logic [AW-1:0] D_INIT = AW'(1);

    // Operation registers.
    mode_t            mode_reg;
    logic [KEY_W-1:0] key_reg;
    logic             quad_reg;

    // Modulo units.
    logic          home_busy, tab_busy;
    logic [HW-1:0] home_rem;
    logic [AW-1:0] tab_rem;
    logic [AW-1:0] home_addr;

    // Walk state.
    logic [CW-1:0] cnt_reg;
    logic [AW-1:0] p_reg, d_reg;
    logic [AW:0]   p_sum, p_wrap, d_sum, d_wrap;
    logic          issue;

    // Memory access.
    logic [KEY_W:0] mem [TABLE_SIZE];
    logic [KEY_W:0] rd_data_reg;
    logic           rd_valid_reg;
    logic [AW-1:0]  chk_addr_reg;
    logic           rd_en;
    logic [AW-1:0]  rd_addr;
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    logic [KEY_W:0] wr_data;
    logic [CW-1:0]  clr_cnt_reg;

    // Result and output registers.
    status_t           res_status_reg;
    logic [SLOT_W-1:0] res_slot_reg;
    status_t           out_status_reg;
    logic [SLOT_W-1:0] out_slot_reg;
    logic              out_valid_reg, out_valid_next;

    oaht_mod #(.MODULUS(HOME_MODULUS)) u_home_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.load),
        .key   (in_key),
        .busy  (home_busy),
        .rem   (home_rem)
    );

    oaht_mod #(.MODULUS(TABLE_SIZE)) u_tab_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.load),
        .key   (in_key),
        .busy  (tab_busy),
        .rem   (tab_rem)
    );

    // Home slot falls back to zero when it lies beyond the table.
    assign home_addr = (HCW'(home_rem) >= HCW'(TABLE_SIZE)) ? '0 : AW'(home_rem);

    // Next probe position and step, both kept below the table size.
    always_comb
    begin
        p_sum  = {1'b0, p_reg} + {1'b0, d_reg};
        p_wrap = (p_sum >= TS_EXT) ? (p_sum - TS_EXT) : p_sum;
        d_sum  = {1'b0, d_reg} + (AW + 1)'(2);
        d_wrap = (d_sum >= TS_EXT) ? (d_sum - TS_EXT) : d_sum;
    end

    assign issue = cmd.walk_run && (cnt_reg != TS_CNT);

    // Read port address: home slot, probe position or scan index.
    always_comb
    begin
        rd_en   = cmd.home_read || issue;
        rd_addr = cnt_reg[AW-1:0];
        if (cmd.home_read)
        begin
            rd_addr = home_addr;
        end
        else if (mode_reg == MODE_INSERT)
        begin
            rd_addr = p_reg;
        end
    end

    // Write port: clearing sweep, key store or slot release.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = chk_addr_reg;
        wr_data = '0;
        if (cmd.clr_step)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_cnt_reg[AW-1:0];
        end
        else if (cmd.wr_key)
        begin
            wr_en   = 1'b1;
            wr_data = {1'b1, key_reg};
        end
        else if (cmd.wr_free)
        begin
            wr_en = 1'b1;
        end
    end

    // Table memory, each word a valid bit over the key.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg  <= mem[rd_addr];
            chk_addr_reg <= rd_addr;
        end
    end

    // Control registers of the datapath.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            rd_valid_reg  <= 1'b0;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg  <= rd_en;
            out_valid_reg <= out_valid_next;
            if (cmd.walk_init)
            begin
                cnt_reg <= '0;
            end
            else if (issue)
            begin
                cnt_reg <= cnt_reg + CW'(1);
            end
            if (cmd.clr_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + CW'(1);
            end
        end
    end

    // Operation, probe and result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= in_mode;
            key_reg  <= in_key;
            quad_reg <= in_quadratic;
        end
        if (cmd.walk_init)
        begin
            p_reg <= tab_rem;
            d_reg <= D_INIT;
        end
        else if (issue)
        begin
            p_reg <= p_wrap[AW-1:0];
            if (quad_reg)
            begin
                d_reg <= d_wrap[AW-1:0];
            end
        end
        if (cmd.res_load)
        begin
            res_status_reg <= cmd.res_status;
            res_slot_reg   <= cmd.res_use_slot ? SLOT_W'(chk_addr_reg) : '0;
        end
        if (cmd.out_load)
        begin
            out_status_reg <= res_status_reg;
            out_slot_reg   <= res_slot_reg;
        end
    end

    // Output register holds until the receiver takes the transfer.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Status toward the controller; an insert looks for a free slot, the rest for the key.
    always_comb
    begin
        sts.mode     = mode_reg;
        sts.mod_busy = home_busy || tab_busy;
        sts.walk_end = (cnt_reg == TS_CNT) && !rd_valid_reg;
        sts.clr_done = (clr_cnt_reg == TS_CNT);
        sts.out_free = !out_valid_reg || out_ready;
        if (mode_reg == MODE_INSERT)
        begin
            sts.hit = rd_valid_reg && !rd_data_reg[KEY_W];
        end
        else
        begin
            sts.hit = rd_valid_reg && rd_data_reg[KEY_W]
                      && (rd_data_reg[KEY_W-1:0] == key_reg);
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_slot   = out_slot_reg;

endmodule

// ----- src/oaht_ctrl.sv -----
// Controller state machine of the hash table: sequences clearing, probing and scanning.
// Uses oaht_pkg for the command and status structs and the codes.
module oaht_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output oaht_pkg::cmd_t cmd,
    input  oaht_pkg::sts_t sts
);
    import oaht_pkg::*;

    localparam logic [2:0] S_CLEAR    = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_MOD      = 3'd2;
    localparam logic [2:0] S_HOME     = 3'd3;
    localparam logic [2:0] S_HOME_CHK = 3'd4;
    localparam logic [2:0] S_WALK     = 3'd5;
    localparam logic [2:0] S_RESULT   = 3'd6;

    logic [2:0] state_reg, state_next;

    assign in_ready = (state_reg == S_IDLE);

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (sts.clr_done)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.clr_step = 1'b1;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load      = 1'b1;
                    cmd.walk_init = 1'b1;
                    state_next    = S_MOD;
                end
            end
            S_MOD:
            begin
                unique case (sts.mode) inside
                    MODE_INSERT:
                    begin
                        if (!sts.mod_busy)
                        begin
                            state_next = S_HOME;
                        end
                    end
                    MODE_SEARCH, MODE_DELETE:
                    begin
                        state_next = S_WALK;
                    end
                    default:
                    begin
                        cmd.res_load   = 1'b1;
                        cmd.res_status = ST_MISSING;
                        state_next     = S_RESULT;
                    end
                endcase
            end
            S_HOME:
            begin
                cmd.home_read = 1'b1;
                state_next    = S_HOME_CHK;
            end
            S_HOME_CHK:
            begin
                if (sts.hit)
                begin
                    cmd.wr_key       = 1'b1;
                    cmd.res_load     = 1'b1;
                    cmd.res_status   = ST_DONE;
                    cmd.res_use_slot = 1'b1;
                    state_next       = S_RESULT;
                end
                else
                begin
                    cmd.walk_init = 1'b1;
                    state_next    = S_WALK;
                end
            end
            S_WALK:
            begin
                cmd.walk_run = 1'b1;
                if (sts.hit)
                begin
                    cmd.wr_key       = (sts.mode == MODE_INSERT);
                    cmd.wr_free      = (sts.mode == MODE_DELETE);
                    cmd.res_load     = 1'b1;
                    cmd.res_status   = ST_DONE;
                    cmd.res_use_slot = 1'b1;
                    state_next       = S_RESULT;
                end
                else if (sts.walk_end)
                begin
                    cmd.res_load   = 1'b1;
                    cmd.res_status = (sts.mode == MODE_INSERT) ? ST_FULL : ST_MISSING;
                    state_next     = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register; reset starts the clearing sweep.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ----- src/open_addressing_hash_table.sv -----
// Open-addressing hash table with linear or quadratic probing, one operation per transfer.
//
// Usage:
//   The s_ channel takes one operation per transfer: insert, search or delete of a key.
//   The m_ channel returns exactly one result per operation, in order: a status code
//   (done, table full or key not found) and the slot that was stored, found or freed.
//   Keys live in a memory of TABLE_SIZE words with one read and one write port.
//   An insert first reduces the key by reciprocal multiplication, then reads its
//   home slot and, if that is taken, walks the probe sequence one memory read per cycle.
//   Search and delete scan the table from slot 0, one read per cycle.
//   The memory read port, one slot per cycle, sets the probe and scan time. One
//   operation is in flight at a time; the controller returns to idle and raises
//   s_tready as the result enters the output register.
//   After reset the block clears the table with s_tready low.
//   The finished result sits in an output register, so the next operation is accepted
//   while m_tvalid waits on m_tready; a further result waits until that one is taken.
// Uses oaht_pkg, oaht_ctrl and oaht_dp.
module open_addressing_hash_table #(
    parameter int TABLE_SIZE   = 64,
    parameter int HOME_MODULUS = 100
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata: mode [1:0], key [32:2], quadratic [33], zero [39:34]
    input  logic [oaht_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata: status [1:0], slot [7:2]
    output logic [oaht_pkg::M_DATA_W-1:0]   m_tdata
);
    import oaht_pkg::*;

    cmd_t              cmd;
    sts_t              sts;
    status_t           res_status;
    logic [SLOT_W-1:0] res_slot;

    oaht_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    oaht_dp #(
        .TABLE_SIZE   (TABLE_SIZE),
        .HOME_MODULUS (HOME_MODULUS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .in_mode      (s_tdata[MODE_W-1:0]),
        .in_key       (s_tdata[MODE_W+KEY_W-1:MODE_W]),
        .in_quadratic (s_tdata[MODE_W+KEY_W]),
        .out_ready    (m_tready),
        .out_valid    (m_tvalid),
        .out_status   (res_status),
        .out_slot     (res_slot)
    );

    assign m_tdata = {res_slot, res_status};

endmodule

// ----- verif/hash_table_checker.sv -----
`timescale 1ns / 1ps
// Scoreboard for the open-addressing hash table. It predicts each result from the
// operations accepted on the s_ stream and compares it with the m_ stream.
// Depends on oaht_pkg.
module hash_table_checker #(
    parameter int TABLE_SIZE   = 64,
    parameter int HOME_MODULUS = 100
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [oaht_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [oaht_pkg::M_DATA_W-1:0] m_tdata,
    output int                            fail_count,
    output int                            pending,
    output int                            done_count,
    output int                            full_count,
    output int                            missing_count
);
    import oaht_pkg::*;

    // One operation as it travels on s_tdata, lowest field last.
    typedef struct packed {
        logic [S_DATA_W-MODE_W-KEY_W-2:0] pad;
        logic                             quadratic;
        logic [KEY_W-1:0]                 key;
        mode_t                            mode;
    } table_op_t;

    // One result as it travels on m_tdata.
    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        status_t           status;
    } table_result_t;

    // Predicted table contents and the results still owed by the block.
    logic [KEY_W-1:0] table_keys [TABLE_SIZE];
    logic             table_used [TABLE_SIZE];
    table_result_t    awaited_results [$];

    task automatic report_mismatch(input string what);
        fail_count++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Lowest occupied slot holding the key, or -1.
    function automatic int find_lowest(input logic [KEY_W-1:0] key);
        for (int s = 0; s < TABLE_SIZE; s++)
        begin
            if (table_used[s] && table_keys[s] == key)
                return s;
        end
        return -1;
    endfunction

    // Applies one operation to the predicted table and returns its result.
    function automatic table_result_t apply_op(input table_op_t op);
        table_result_t   res;
        int              hit;
        logic            found;
        longint unsigned home;
        longint unsigned pos;
        res.status = ST_MISSING;
        res.slot   = '0;
        case (op.mode)
            MODE_INSERT:
            begin
                // Home slot first, folded to slot 0 when it lies past the table.
                home = 64'(op.key) % 64'(HOME_MODULUS);
                if (home >= 64'(TABLE_SIZE))
                    home = 0;
                found = 1'b0;
                pos   = home;
                if (!table_used[home])
                    found = 1'b1;
                // Home taken: walk the linear or quadratic probe sequence.
                for (int i = 0; i < TABLE_SIZE && !found; i++)
                begin
                    pos = (64'(op.key) + (op.quadratic ? 64'(i) * 64'(i) : 64'(i)))
                          % 64'(TABLE_SIZE);
                    found = !table_used[pos];
                end
                if (found)
                begin
                    table_used[pos] = 1'b1;
                    table_keys[pos] = op.key;
                    res.status      = ST_DONE;
                    res.slot        = pos[SLOT_W-1:0];
                end
                else
                    res.status = ST_FULL;
            end
            MODE_SEARCH, MODE_DELETE:
            begin
                hit = find_lowest(op.key);
                if (hit >= 0)
                begin
                    if (op.mode == MODE_DELETE)
                        table_used[hit] = 1'b0;
                    res.status = ST_DONE;
                    res.slot   = hit[SLOT_W-1:0];
                end
            end
            default:
            begin
                // The unused code changes nothing and reports a miss.
            end
        endcase
        return res;
    endfunction

    // Check each result transfer against the oldest prediction, then predict new ones.
    always @(posedge clk or negedge rst_n)
    begin : watch_streams
        table_result_t seen;
        table_result_t want;
        if (!rst_n)
        begin
            for (int s = 0; s < TABLE_SIZE; s++)
                table_used[s] = 1'b0;
            awaited_results.delete();
            pending = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                seen = table_result_t'(m_tdata);
                if (awaited_results.size() == 0)
                    report_mismatch(
                        $sformatf("result status %0d slot %0d with no operation waiting",
                                  seen.status, seen.slot));
                else
                begin
                    want = awaited_results.pop_front();
                    if (seen.status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  seen.status, want.status));
                    if (seen.slot !== want.slot)
                        report_mismatch($sformatf("slot %0d, expected %0d",
                                                  seen.slot, want.slot));
                end
                case (seen.status)
                    ST_DONE: done_count++;
                    ST_FULL: full_count++;
                    default: missing_count++;
                endcase
            end
            if (s_tvalid && s_tready)
                awaited_results.push_back(apply_op(table_op_t'(s_tdata)));
            pending = awaited_results.size();
        end
    end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench top for the open-addressing hash table: clock, reset, operation stimulus
// with bursts, receiver stalls, a watchdog and the verdict.
// Depends on oaht_pkg, open_addressing_hash_table and hash_table_checker.
module tb_top;
    import oaht_pkg::*;

    localparam int TABLE_SIZE   = 64;
    localparam int HOME_MODULUS = 100;
    localparam int IDLE_LIMIT   = 5000;
    localparam int ROUNDS       = 7;
    localparam int ROUND_OPS    = 100;
    localparam int POOL_SIZE    = 24;
    localparam int DRAIN_CYCLES = 80;
    localparam int HOLD_CYCLES  = 600;

    // The one mode code the block does not define.
    localparam mode_t MODE_UNUSED = 2'd3;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;

    int fail_count;
    int pending;
    int done_count;
    int full_count;
    int missing_count;
    int results_out;
    int idle_cycles;
    int op_counts [4];
    int burst_left;

    logic [KEY_W-1:0] key_pool [POOL_SIZE];
    logic [KEY_W-1:0] issued_keys [$];

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    open_addressing_hash_table #(
        .TABLE_SIZE   (TABLE_SIZE),
        .HOME_MODULUS (HOME_MODULUS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    hash_table_checker #(
        .TABLE_SIZE   (TABLE_SIZE),
        .HOME_MODULUS (HOME_MODULUS)
    ) result_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .fail_count    (fail_count),
        .pending       (pending),
        .done_count    (done_count),
        .full_count    (full_count),
        .missing_count (missing_count)
    );

    // Count result transfers and cycles in which neither stream moves.
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            results_out <= results_out + 1;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Watchdog: the block has stopped moving.
    initial
    begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("timeout after %0d cycles without a transfer", IDLE_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    // Receiver: changing stall styles, plus two long hold-offs that back up the block.
    initial
    begin : receiver
        int style;
        int style_left;
        int hold_left;
        int holds_done;
        int hold_points [2];
        style       = 0;
        style_left  = 0;
        hold_left   = 0;
        holds_done  = 0;
        hold_points = '{120, 450};
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (style_left == 0)
            begin
                style      = $urandom_range(0, 3);
                style_left = $urandom_range(40, 300);
            end
            style_left--;
            if (hold_left == 0 && holds_done < 2 && results_out >= hold_points[holds_done])
            begin
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                case (style)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= (style_left % 4 == 0);
                    default: m_tready <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    function automatic logic [KEY_W-1:0] any_key();
        logic [31:0] r;
        r = $urandom();
        return r[KEY_W-1:0];
    endfunction

    // Inserts favor a small pool so that duplicates and later hits are common.
    function automatic logic [KEY_W-1:0] insert_key();
        if ($urandom_range(0, 9) < 6)
            return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        return any_key();
    endfunction

    // Lookups mostly target keys inserted earlier; a delete retires its pick.
    function automatic logic [KEY_W-1:0] lookup_key(input bit retire);
        int pick;
        int idx;
        pick = $urandom_range(0, 9);
        if (pick < 7 && issued_keys.size() > 0)
        begin
            idx        = $urandom_range(0, issued_keys.size() - 1);
            lookup_key = issued_keys[idx];
            if (retire)
                issued_keys.delete(idx);
        end
        else if (pick < 9)
            lookup_key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        else
            lookup_key = any_key();
    endfunction

    // Offers one operation, waits for its transfer, then may idle if the burst is over.
    // Entered and left at a falling edge.
    task automatic send_op(input mode_t op, input logic [KEY_W-1:0] key, input logic quad);
        int gap;
        s_tdata  <= {{(S_DATA_W - MODE_W - KEY_W - 1){1'b0}}, quad, key, op};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        op_counts[op]++;
        if (op == MODE_INSERT)
            issued_keys.push_back(key);
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap        = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    task automatic pause_until_drained();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
    endtask

    initial
    begin : stimulus
        int    pick;
        int    ins_pct;
        int    del_pct;
        key_pool[0] = '0;
        key_pool[1] = '1;
        key_pool[2] = 31'd63;
        key_pool[3] = 31'd64;
        key_pool[4] = 31'd99;
        key_pool[5] = 31'd100;
        key_pool[6] = 31'd163;
        for (int k = 7; k < POOL_SIZE; k++)
            key_pool[k] = (k % 2 == 0) ? any_key() : 31'($urandom_range(0, 999));
        burst_left = $urandom_range(1, 16);

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part: home slot, home past the table, duplicates, both probe kinds,
        // the largest key, hits and misses for search and delete, and the unused code.
        send_op(MODE_INSERT, 31'd0, 1'b0);
        send_op(MODE_INSERT, 31'd0, 1'b0);
        send_op(MODE_INSERT, 31'd64, 1'b0);
        send_op(MODE_INSERT, 31'd99, 1'b1);
        send_op(MODE_INSERT, '1, 1'b1);
        send_op(MODE_INSERT, 31'd147, 1'b1);
        send_op(MODE_INSERT, 31'd2, 1'b1);
        send_op(MODE_SEARCH, 31'd0, 1'b0);
        send_op(MODE_SEARCH, '1, 1'b1);
        send_op(MODE_SEARCH, 31'd12345, 1'b0);
        send_op(MODE_DELETE, 31'd0, 1'b0);
        send_op(MODE_DELETE, 31'd0, 1'b1);
        send_op(MODE_DELETE, 31'd0, 1'b0);
        send_op(MODE_UNUSED, '1, 1'b1);
        send_op(MODE_UNUSED, 31'd2, 1'b0);
        send_op(MODE_INSERT, 31'd100, 1'b0);
        send_op(MODE_SEARCH, 31'd64, 1'b1);
        send_op(MODE_DELETE, '1, 1'b0);
        pause_until_drained();

        // Random rounds cycle through fill-up, steady churn and draining of the table.
        for (int r = 0; r < ROUNDS; r++)
        begin
            case (r % 3)
                0:
                begin
                    ins_pct = 85;
                    del_pct = 5;
                end
                1:
                begin
                    ins_pct = 40;
                    del_pct = 25;
                end
                default:
                begin
                    ins_pct = 15;
                    del_pct = 50;
                end
            endcase
            repeat (ROUND_OPS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 2)
                    send_op(MODE_UNUSED, any_key(), 1'($urandom_range(0, 1)));
                else if (pick < ins_pct)
                    send_op(MODE_INSERT, insert_key(), 1'($urandom_range(0, 1)));
                else if (pick < ins_pct + del_pct)
                    send_op(MODE_DELETE, lookup_key(1'b1), 1'($urandom_range(0, 1)));
                else
                    send_op(MODE_SEARCH, lookup_key(1'b0), 1'($urandom_range(0, 1)));
            end
            if (r % 2 == 1)
                pause_until_drained();
        end

        pause_until_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Ran %0d inserts, %0d searches, %0d deletes and %0d unused-code operations.",
                 op_counts[MODE_INSERT], op_counts[MODE_SEARCH], op_counts[MODE_DELETE],
                 op_counts[MODE_UNUSED]);
        $display("Results: %0d done, %0d table full, %0d key not found.",
                 done_count, full_count, missing_count);
        if (fail_count == 0 && pending == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
